// File: hw/rtl/gtpud_pkg.sv
// Shared types and constants for the GTP-U uplink deframer.
package gtpud_pkg;

  // Verdict codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_IP_VER    = 4'd2;
  localparam logic [3:0] ST_NOT_UDP   = 4'd3;
  localparam logic [3:0] ST_PORT      = 4'd4;
  localparam logic [3:0] ST_GTP_VER   = 4'd5;
  localparam logic [3:0] ST_MSG_TYPE  = 4'd6;
  localparam logic [3:0] ST_EXT_SHORT = 4'd7;
  localparam logic [3:0] ST_LENGTH    = 4'd8;

  // Header byte positions (20-byte IPv4 header, no options)
  localparam logic [15:0] POS_IP_VER    = 16'd0;
  localparam logic [15:0] POS_IP_PROTO  = 16'd9;
  localparam logic [15:0] POS_SRC_FIRST = 16'd12;
  localparam logic [15:0] POS_SRC_LAST  = 16'd15;
  localparam logic [15:0] POS_DPORT_HI  = 16'd22;
  localparam logic [15:0] POS_DPORT_LO  = 16'd23;
  localparam logic [15:0] POS_GTP_FLAGS = 16'd28;
  localparam logic [15:0] POS_GTP_TYPE  = 16'd29;
  localparam logic [15:0] POS_GLEN_HI   = 16'd30;
  localparam logic [15:0] POS_GLEN_LO   = 16'd31;
  localparam logic [15:0] POS_TEID_FIRST = 16'd32;
  localparam logic [15:0] POS_TEID_LAST  = 16'd35;
  localparam logic [15:0] POS_SEQ_HI    = 16'd36;
  localparam logic [15:0] POS_SEQ_LO    = 16'd37;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Check constants
  localparam logic [15:0] MIN_PKT_LEN = 16'd36;  // outer headers + base GTP header
  localparam logic [15:0] EXT_PKT_LEN = 16'd40;  // with the optional 4-byte part
  localparam logic [16:0] INNER_BASE  = 17'd36;
  localparam logic [3:0]  IP_V4       = 4'd4;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [7:0]  VER_MASK    = 8'hE0;
  localparam logic [7:0]  VER_V1      = 8'h20;
  localparam logic [7:0]  TPDU_TYPE   = 8'hFF;
  localparam logic [7:0]  OPT_MASK    = 8'h07;  // E, S, PN
  localparam int          FLAG_S_BIT  = 1;
  localparam logic [15:0] OPT_LEN     = 16'd4;
  localparam logic [15:0] PORT_RESET  = 16'd2152;
  localparam logic [5:0]  OFF_BASE    = 6'd36;
  localparam logic [5:0]  OFF_EXT     = 6'd40;

  // Header summary of one finished packet
  typedef struct packed {
    logic [15:0] len;
    logic [3:0]  ip_ver;
    logic [7:0]  ip_protocol;
    logic [15:0] dest_port;
    logic [7:0]  gtp_flags;
    logic [7:0]  gtp_type;
    logic [15:0] gtp_length;
    logic [31:0] teid_word;
    logic [15:0] seq_word;
    logic [31:0] source_addr;
  } rec_t;

  // One verdict
  typedef struct packed {
    logic [15:0] inner_length;
    logic [5:0]  inner_offset;
    logic [31:0] outer_source;
    logic [15:0] seq_number;
    logic [31:0] tunnel_id;
    logic [3:0]  status;
  } res_t;

  // Front to queue
  typedef struct packed {
    logic push;
    rec_t rec;
  } push_t;

endpackage

// File: hw/rtl/gtpud_front.sv
// Byte parser: counts bytes, captures header fields, emits a summary per packet.
module gtpud_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic                  byte_ready,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_packet,
  output gtpud_pkg::push_t      push_out
);

  logic [15:0] byte_count;
  logic [7:0]  ip_first_byte, ip_first_byte_next;
  logic [7:0]  ip_protocol, ip_protocol_next;
  logic [31:0] source_addr, source_addr_next;
  logic [15:0] dest_port, dest_port_next;
  logic [7:0]  gtp_flags, gtp_flags_next;
  logic [7:0]  gtp_type, gtp_type_next;
  logic [15:0] gtp_length, gtp_length_next;
  logic [31:0] teid_word, teid_word_next;
  logic [15:0] seq_word, seq_word_next;
  logic [15:0] count_inc;
  logic        acc;

  assign acc       = byte_valid && byte_ready;
  assign count_inc = (byte_count == gtpud_pkg::COUNT_MAX) ? byte_count : byte_count + 16'd1;

  always_comb begin
    ip_first_byte_next = ip_first_byte;
    ip_protocol_next   = ip_protocol;
    source_addr_next   = source_addr;
    dest_port_next     = dest_port;
    gtp_flags_next     = gtp_flags;
    gtp_type_next      = gtp_type;
    gtp_length_next    = gtp_length;
    teid_word_next     = teid_word;
    seq_word_next      = seq_word;
    if (byte_count == gtpud_pkg::POS_IP_VER) begin
      ip_first_byte_next = data_byte;
    end else if (byte_count == gtpud_pkg::POS_IP_PROTO) begin
      ip_protocol_next = data_byte;
    end else if (byte_count >= gtpud_pkg::POS_SRC_FIRST &&
                 byte_count <= gtpud_pkg::POS_SRC_LAST) begin
      source_addr_next = {source_addr[23:0], data_byte};
    end else if (byte_count == gtpud_pkg::POS_DPORT_HI ||
                 byte_count == gtpud_pkg::POS_DPORT_LO) begin
      dest_port_next = {dest_port[7:0], data_byte};
    end else if (byte_count == gtpud_pkg::POS_GTP_FLAGS) begin
      gtp_flags_next = data_byte;
    end else if (byte_count == gtpud_pkg::POS_GTP_TYPE) begin
      gtp_type_next = data_byte;
    end else if (byte_count == gtpud_pkg::POS_GLEN_HI ||
                 byte_count == gtpud_pkg::POS_GLEN_LO) begin
      gtp_length_next = {gtp_length[7:0], data_byte};
    end else if (byte_count >= gtpud_pkg::POS_TEID_FIRST &&
                 byte_count <= gtpud_pkg::POS_TEID_LAST) begin
      teid_word_next = {teid_word[23:0], data_byte};
    end else if (byte_count == gtpud_pkg::POS_SEQ_HI ||
                 byte_count == gtpud_pkg::POS_SEQ_LO) begin
      seq_word_next = {seq_word[7:0], data_byte};
    end
  end

  // Fields are always rewritten before any check that reads them, so no clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (acc) begin
      byte_count <= end_of_packet ? 16'd0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ip_first_byte <= ip_first_byte_next;
      ip_protocol   <= ip_protocol_next;
      source_addr   <= source_addr_next;
      dest_port     <= dest_port_next;
      gtp_flags     <= gtp_flags_next;
      gtp_type      <= gtp_type_next;
      gtp_length    <= gtp_length_next;
      teid_word     <= teid_word_next;
      seq_word      <= seq_word_next;
    end
  end

  always_comb begin
    push_out.push            = acc && end_of_packet;
    push_out.rec.len         = count_inc;
    push_out.rec.ip_ver      = ip_first_byte_next[7:4];
    push_out.rec.ip_protocol = ip_protocol_next;
    push_out.rec.dest_port   = dest_port_next;
    push_out.rec.gtp_flags   = gtp_flags_next;
    push_out.rec.gtp_type    = gtp_type_next;
    push_out.rec.gtp_length  = gtp_length_next;
    push_out.rec.teid_word   = teid_word_next;
    push_out.rec.seq_word    = seq_word_next;
    push_out.rec.source_addr = source_addr_next;
  end

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    acc && end_of_packet |=> byte_count == 16'd0)
    else $error("byte count not cleared after last byte");

endmodule

// File: hw/rtl/gtpud_queue.sv
// Small FIFO of packet summaries between parser and verdict stage.
module gtpud_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  gtpud_pkg::push_t  push_in,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output gtpud_pkg::rec_t   head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gtpud_pkg::rec_t entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push_in.push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_in.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");

  a_push_lost: assert property (@(posedge clk) disable iff (rst)
    push_in.push |-> !full)
    else $error("summary pushed into full queue");

endmodule

// File: hw/rtl/gtpud_back.sv
// Verdict stage: runs the ordered checks on a packet summary, holds the result.
module gtpud_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  input  logic             rec_valid,
  input  gtpud_pkg::rec_t  rec,
  output logic             rec_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output gtpud_pkg::res_t  out_res
);

  logic [15:0]     tunnel_udp_port;
  gtpud_pkg::res_t res_next;
  logic            opt;
  logic            too_long;
  logic            no_payload;
  logic [16:0]     need_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      tunnel_udp_port <= gtpud_pkg::PORT_RESET;
    end else if (cfg_we) begin
      tunnel_udp_port <= cfg_wdata;
    end
  end

  assign opt        = |(rec.gtp_flags & gtpud_pkg::OPT_MASK);
  // header + payload against bytes present reduces to length + 36 > len for both forms
  assign need_len   = {1'b0, rec.gtp_length} + gtpud_pkg::INNER_BASE;
  assign too_long   = need_len > {1'b0, rec.len};
  assign no_payload = opt ? (rec.gtp_length <= gtpud_pkg::OPT_LEN) : (rec.gtp_length == '0);

  always_comb begin
    res_next = '0;
    if (rec.len < gtpud_pkg::MIN_PKT_LEN) begin
      res_next.status = gtpud_pkg::ST_SHORT;
    end else if (rec.ip_ver != gtpud_pkg::IP_V4) begin
      res_next.status = gtpud_pkg::ST_IP_VER;
    end else if (rec.ip_protocol != gtpud_pkg::PROTO_UDP) begin
      res_next.status = gtpud_pkg::ST_NOT_UDP;
    end else if (rec.dest_port != tunnel_udp_port) begin
      res_next.status = gtpud_pkg::ST_PORT;
    end else if ((rec.gtp_flags & gtpud_pkg::VER_MASK) != gtpud_pkg::VER_V1) begin
      res_next.status = gtpud_pkg::ST_GTP_VER;
    end else if (rec.gtp_type != gtpud_pkg::TPDU_TYPE) begin
      res_next.status = gtpud_pkg::ST_MSG_TYPE;
    end else if (opt && rec.len < gtpud_pkg::EXT_PKT_LEN) begin
      res_next.status = gtpud_pkg::ST_EXT_SHORT;
    end else if (no_payload || too_long) begin
      res_next.status = gtpud_pkg::ST_LENGTH;
    end else begin
      res_next.status       = gtpud_pkg::ST_OK;
      res_next.tunnel_id    = rec.teid_word;
      res_next.seq_number   = rec.gtp_flags[gtpud_pkg::FLAG_S_BIT] ? rec.seq_word : 16'd0;
      res_next.outer_source = rec.source_addr;
      res_next.inner_offset = opt ? gtpud_pkg::OFF_EXT : gtpud_pkg::OFF_BASE;
      res_next.inner_length = opt ? rec.gtp_length - gtpud_pkg::OPT_LEN : rec.gtp_length;
    end
  end

  assign rec_pop = rec_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_res <= res_next;
    end
  end

  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == gtpud_pkg::ST_OK |->
      out_res.inner_offset == gtpud_pkg::OFF_BASE ||
      out_res.inner_offset == gtpud_pkg::OFF_EXT)
    else $error("accepted packet with bad inner offset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status != gtpud_pkg::ST_OK |->
      out_res.tunnel_id == '0 && out_res.inner_length == '0 &&
      out_res.outer_source == '0)
    else $error("failed verdict carries header fields");

endmodule

// File: hw/rtl/gtpu_uplink_deframer.sv
// Top level of the GTP-U v1 uplink deframer.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-----------------------------------------
//  s_       | in  | s_tvalid/s_tready | s_tdata[7:0] data_byte, s_tlast end_of_packet
//  m_       | out | m_tvalid/m_tready | m_tdata verdict (see port comment)
//  cfg_     | in  | cfg_we            | cfg_wdata tunnel_udp_port
//
// One byte per cycle is taken while s_tready is high. The parser counts bytes and
// captures header fields; on the last byte it pushes a header summary into a
// QUEUE_DEPTH entry queue. The verdict stage pops one summary per cycle while m_
// is not stalled, runs the ordered checks and holds the result in an output
// register, from which the verdict shows on m_. s_tready falls only when
// QUEUE_DEPTH verdicts are waiting behind a stalled m_. Reset is synchronous: it
// clears byte count, queue and output, and loads the port register with 2152.
module gtpu_uplink_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // [7:0] data_byte
  input  logic         s_tlast,    // end_of_packet
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] status, [35:4] tunnel_id, [51:36] seq_number, [83:52] outer_source,
  // [89:84] inner_offset, [105:90] inner_length, [111:106] zero
  output logic [111:0] m_tdata,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata   // tunnel_udp_port
);

  gtpud_pkg::push_t push;
  gtpud_pkg::rec_t  head;
  gtpud_pkg::res_t  res;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;

  // Accept as long as the queue has room for a summary.
  assign s_tready = !q_full;

  gtpud_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (s_tvalid),
    .byte_ready    (s_tready),
    .data_byte     (s_tdata),
    .end_of_packet (s_tlast),
    .push_out      (push)
  );

  gtpud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_in   (push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  gtpud_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rec_valid (q_not_empty),
    .rec       (head),
    .rec_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // res_t is packed status-first from the low end; pad to whole bytes.
  assign m_tdata = {6'd0, res};

endmodule

// File: verif/gtpu_uplink_deframer_checker.sv
// Verdict predictor and scoreboard for the GTP-U uplink deframer.
module gtpu_uplink_deframer_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           verdicts_waiting,
  output int           verdicts_checked,
  output logic [8:0]   status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GTP_BASE_HDR = 8;
  localparam int GTP_EXT_HDR  = 12;

  // mirrored port register and per-packet capture
  logic [15:0] udp_port;
  logic [15:0] rx_count;
  logic [7:0]  ver_byte;
  logic [7:0]  proto_byte;
  logic [31:0] src_addr;
  logic [15:0] dport;
  logic [7:0]  flags_byte;
  logic [7:0]  type_byte;
  logic [15:0] glen_word;
  logic [31:0] teid;
  logic [15:0] seq;

  gtpud_pkg::res_t verdict_q[$];
  gtpud_pkg::res_t want;
  gtpud_pkg::res_t got;
  bit              ok;
  int              mismatches = 0;
  int              checked = 0;
  logic [8:0]      status_mask = '0;

  task automatic clear_capture();
    rx_count   = '0;
    ver_byte   = '0;
    proto_byte = '0;
    src_addr   = '0;
    dport      = '0;
    flags_byte = '0;
    type_byte  = '0;
    glen_word  = '0;
    teid       = '0;
    seq        = '0;
  endtask

  task automatic take_byte(input logic [15:0] pos, input logic [7:0] b);
    if (pos == gtpud_pkg::POS_IP_VER) ver_byte = b;
    else if (pos == gtpud_pkg::POS_IP_PROTO) proto_byte = b;
    else if (pos >= gtpud_pkg::POS_SRC_FIRST && pos <= gtpud_pkg::POS_SRC_LAST)
      src_addr = {src_addr[23:0], b};
    else if (pos == gtpud_pkg::POS_DPORT_HI || pos == gtpud_pkg::POS_DPORT_LO)
      dport = {dport[7:0], b};
    else if (pos == gtpud_pkg::POS_GTP_FLAGS) flags_byte = b;
    else if (pos == gtpud_pkg::POS_GTP_TYPE) type_byte = b;
    else if (pos == gtpud_pkg::POS_GLEN_HI || pos == gtpud_pkg::POS_GLEN_LO)
      glen_word = {glen_word[7:0], b};
    else if (pos >= gtpud_pkg::POS_TEID_FIRST && pos <= gtpud_pkg::POS_TEID_LAST)
      teid = {teid[23:0], b};
    else if (pos == gtpud_pkg::POS_SEQ_HI || pos == gtpud_pkg::POS_SEQ_LO)
      seq = {seq[7:0], b};
  endtask

  // ordered checks on the captured header, first failure wins
  function automatic gtpud_pkg::res_t judge_packet();
    gtpud_pkg::res_t v;
    int              gtp_bytes;
    int              hdr;
    int              payload;
    logic [15:0]     seq_out;
    v         = '0;
    hdr       = GTP_BASE_HDR;
    payload   = int'(glen_word);
    seq_out   = '0;
    gtp_bytes = int'(rx_count) - int'(gtpud_pkg::POS_GTP_FLAGS);
    if (rx_count < gtpud_pkg::MIN_PKT_LEN) v.status = gtpud_pkg::ST_SHORT;
    else if (ver_byte[7:4] != gtpud_pkg::IP_V4) v.status = gtpud_pkg::ST_IP_VER;
    else if (proto_byte != gtpud_pkg::PROTO_UDP) v.status = gtpud_pkg::ST_NOT_UDP;
    else if (dport != udp_port) v.status = gtpud_pkg::ST_PORT;
    else if ((flags_byte & gtpud_pkg::VER_MASK) != gtpud_pkg::VER_V1)
      v.status = gtpud_pkg::ST_GTP_VER;
    else if (type_byte != gtpud_pkg::TPDU_TYPE) v.status = gtpud_pkg::ST_MSG_TYPE;
    else begin
      v.status = gtpud_pkg::ST_OK;
      if ((flags_byte & gtpud_pkg::OPT_MASK) != 8'd0) begin
        if (gtp_bytes < GTP_EXT_HDR) v.status = gtpud_pkg::ST_EXT_SHORT;
        else begin
          if (flags_byte[gtpud_pkg::FLAG_S_BIT]) seq_out = seq;
          hdr     = GTP_EXT_HDR;
          payload = payload - 4;
        end
      end
      if (v.status == gtpud_pkg::ST_OK && (payload <= 0 || hdr + payload > gtp_bytes))
        v.status = gtpud_pkg::ST_LENGTH;
    end
    if (v.status == gtpud_pkg::ST_OK) begin
      v.tunnel_id    = teid;
      v.seq_number   = seq_out;
      v.outer_source = src_addr;
      v.inner_offset = (hdr == GTP_EXT_HDR) ? gtpud_pkg::OFF_EXT : gtpud_pkg::OFF_BASE;
      v.inner_length = 16'(payload);
    end
    return v;
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns verdict %s: expected %h actual %h", $time, name, exp_val, act_val);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      udp_port = gtpud_pkg::PORT_RESET;
      clear_capture();
      verdict_q.delete();
    end else begin
      if (cfg_we) udp_port = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got = gtpud_pkg::res_t'(m_tdata[105:0]);
        if (verdict_q.size() == 0) begin
          $display("%0t ns verdict with none expected: expected none actual %h",
                   $time, m_tdata);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          ok = 1'b1;
          ok &= field_ok("status", 32'(want.status), 32'(got.status));
          ok &= field_ok("tunnel_id", want.tunnel_id, got.tunnel_id);
          ok &= field_ok("seq_number", 32'(want.seq_number), 32'(got.seq_number));
          ok &= field_ok("outer_source", want.outer_source, got.outer_source);
          ok &= field_ok("inner_offset", 32'(want.inner_offset), 32'(got.inner_offset));
          ok &= field_ok("inner_length", 32'(want.inner_length), 32'(got.inner_length));
          ok &= field_ok("pad", 32'd0, 32'(m_tdata[111:106]));
          if (!ok) mismatches++;
          status_mask[want.status] = 1'b1;
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        take_byte(rx_count, s_tdata);
        if (rx_count != gtpud_pkg::COUNT_MAX) rx_count++;
        if (s_tlast) begin
          verdict_q.push_back(judge_packet());
          clear_capture();
        end
      end
    end
    verdicts_waiting <= verdict_q.size();
    fail_count       <= mismatches;
    verdicts_checked <= checked;
    status_seen      <= status_mask;
  end

endmodule

// File: verif/gtpu_uplink_deframer_tb.sv
// Stimulus and verdict for the GTP-U uplink deframer testbench.
module gtpu_uplink_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // receiver hold-off long enough to fill the verdict queue and stall s_
  localparam int HOLD_CYCLES   = 600;
  // no word moved on either side for this long means the block is stuck
  localparam int IDLE_LIMIT    = 5000;
  // let the verdict pipe settle before a cfg write
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_BYTES   = 150;
  localparam int PHASE_PKTS    = 3;

  // packet shapes: which check the packet is built to trip
  typedef enum int {
    PK_GOOD, PK_SHORT, PK_EXT_SHORT, PK_IP_VER, PK_NOT_UDP,
    PK_PORT, PK_GTP_VER, PK_MSG_TYPE, PK_LENGTH, PK_NOISE
  } pkt_kind_t;

  typedef enum int { RX_RANDOM, RX_ALWAYS, RX_PERIODIC, RX_SPARSE } rx_mode_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;

  int         fail_count;
  int         verdicts_waiting;
  int         verdicts_checked;
  logic [8:0] status_seen;

  // stimulus state
  logic [7:0]  pkt_bytes[$];
  logic [15:0] cur_port = gtpud_pkg::PORT_RESET;   // what the block's register should hold now
  bit          stream_gaps = 1'b1;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          pkts_sent = 0;
  int          phase_bytes;
  int          phase_pkts;

  // receiver and watchdog state
  rx_mode_t rx_mode = RX_RANDOM;
  bit       hold_req = 1'b0;
  int       rx_tick = 0;
  int       idle_cycles = 0;
  int       in_stalls = 0;

  gtpu_uplink_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  gtpu_uplink_deframer_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .verdicts_waiting (verdicts_waiting),
    .verdicts_checked (verdicts_checked),
    .status_seen      (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One byte word on s_. Bursts of random length; between bursts valid may drop
  // for a random gap when stream_gaps is set. Valid is only lowered when a nonzero gap
  // follows, so it never toggles twice in one step.
  task automatic send_word(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = stream_gaps ? $urandom_range(8) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    phase_bytes++;
  endtask

  // Build a packet with a valid IPv4/UDP/GTP-U header around random content,
  // bend it per kind, then send it. inner: payload bytes; slack: extra bytes
  // after the payload; glen_adj: skew of the GTP length field; trim: cut the
  // packet to this many bytes (noise: its length).
  task automatic issue_packet(input pkt_kind_t kind, input logic [2:0] opt, input int inner,
                              input int slack, input int glen_adj, input int trim);
    int          total;
    int          i;
    int          v;
    logic [15:0] glen;
    logic [15:0] bad_port;
    total = (kind == PK_NOISE) ? trim
          : 28 + ((opt != 3'd0) ? 12 : 8) + inner + slack;
    pkt_bytes.delete();
    for (i = 0; i < total; i++) pkt_bytes.push_back(8'($urandom));
    if (kind != PK_NOISE) begin
      pkt_bytes[0]  = {gtpud_pkg::IP_V4, pkt_bytes[0][3:0]};
      pkt_bytes[9]  = gtpud_pkg::PROTO_UDP;
      pkt_bytes[22] = cur_port[15:8];
      pkt_bytes[23] = cur_port[7:0];
      // version 1, PT and spare bit left random, E/S/PN as asked
      pkt_bytes[28] = {3'b001, pkt_bytes[28][4:3], opt};
      pkt_bytes[29] = gtpud_pkg::TPDU_TYPE;
      glen = 16'(inner + ((opt != 3'd0) ? 4 : 0) + glen_adj);
      pkt_bytes[30] = glen[15:8];
      pkt_bytes[31] = glen[7:0];
      case (kind)
        PK_IP_VER: begin
          v = $urandom_range(14);
          if (v >= 4) v++;
          pkt_bytes[0] = {4'(v), pkt_bytes[0][3:0]};
        end
        PK_NOT_UDP: begin
          v = $urandom_range(254);
          if (v >= 17) v++;
          pkt_bytes[9] = 8'(v);
        end
        PK_PORT: begin
          bad_port = cur_port ^ 16'($urandom_range(1, 65535));
          pkt_bytes[22] = bad_port[15:8];
          pkt_bytes[23] = bad_port[7:0];
        end
        PK_GTP_VER: begin
          v = $urandom_range(6);
          if (v >= 1) v++;
          pkt_bytes[28] = {3'(v), pkt_bytes[28][4:0]};
        end
        PK_MSG_TYPE: pkt_bytes[29] = 8'($urandom_range(254));
        default: ;
      endcase
      if (trim > 0)
        while (pkt_bytes.size() > trim) void'(pkt_bytes.pop_back());
    end
    for (i = 0; i < pkt_bytes.size(); i++)
      send_word(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkts_sent++;
    phase_pkts++;
  endtask

  // About half well-formed packets with random content, the rest broken or noise.
  task automatic random_packet();
    int         r;
    pkt_kind_t  kind;
    logic [2:0] opt;
    int         inner;
    int         slack;
    int         adj;
    int         trim;
    r     = $urandom_range(99);
    opt   = ($urandom_range(1) != 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    inner = ($urandom_range(9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 12);
    slack = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
    adj   = 0;
    trim  = 0;
    kind  = PK_GOOD;
    if (r >= 90) begin
      kind = PK_NOISE;
      trim = $urandom_range(1, 60);
    end else if (r >= 45) begin
      case ($urandom_range(7))
        0: begin kind = PK_SHORT; trim = $urandom_range(1, 35); end
        1: begin
          kind = PK_EXT_SHORT;
          opt  = 3'($urandom_range(1, 7));
          trim = $urandom_range(36, 39);
        end
        2: kind = PK_IP_VER;
        3: kind = PK_NOT_UDP;
        4: kind = PK_PORT;
        5: kind = PK_GTP_VER;
        6: kind = PK_MSG_TYPE;
        default: begin
          kind = PK_LENGTH;
          // either claims more payload than is there, or none at all
          if ($urandom_range(1) != 0) adj = slack + $urandom_range(1, 6);
          else if (opt != 3'd0) adj = -inner - $urandom_range(4);
          else adj = -inner;
        end
      endcase
    end
    issue_packet(kind, opt, inner, slack, adj, trim);
  endtask

  // wait until every predicted verdict has come out, then let the pipe settle
  task automatic drain_verdicts();
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_port(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_port  = value;
  endtask

  // receiver: a pattern per phase, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   m_tready <= 1'b1;
          RX_PERIODIC: m_tready <= ((rx_tick % 7) < 3);
          RX_SPARSE:   m_tready <= ($urandom_range(4) == 0);
          default:     m_tready <= ($urandom_range(3) != 0);
        endcase
        rx_tick++;
        @(posedge clk);
      end
    end
  end

  // watchdog: counts cycles with no word moved on either side
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (s_tvalid && !s_tready) in_stalls++;
    end
    $display("%0t ns watchdog: no traffic for %0d cycles", $time, IDLE_LIMIT);
    $display("gtpu_uplink_deframer: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] phase_port[4];
    rx_mode_t    phase_rx[4];
    int          ph;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed part, register at its reset value; the first packets run into
    // a receiver hold-off so the queue fills and s_ backs up
    hold_req = 1'b1;
    issue_packet(PK_GOOD, 3'b000, 1, 0, 0, 0);        // smallest good packet
    issue_packet(PK_GOOD, 3'b100, 5, 0, 0, 0);        // E only
    issue_packet(PK_GOOD, 3'b010, 8, 2, 0, 0);        // S only, sequence reported
    issue_packet(PK_GOOD, 3'b001, 3, 0, 0, 0);        // PN only
    issue_packet(PK_GOOD, 3'b111, 20, 1, 0, 0);       // all optional flags
    issue_packet(PK_SHORT, 3'b000, 4, 0, 0, 1);       // one byte packet
    issue_packet(PK_SHORT, 3'b000, 4, 0, 0, 35);      // one byte under minimum
    issue_packet(PK_EXT_SHORT, 3'b010, 4, 0, 0, 36);  // optional part missing
    issue_packet(PK_EXT_SHORT, 3'b100, 4, 0, 0, 39);  // optional part one short
    issue_packet(PK_GOOD, 3'b000, 0, 0, 0, 0);        // 36 bytes, zero payload
    issue_packet(PK_IP_VER, 3'b000, 6, 0, 0, 0);
    issue_packet(PK_NOT_UDP, 3'b000, 6, 0, 0, 0);
    issue_packet(PK_PORT, 3'b000, 6, 0, 0, 0);
    issue_packet(PK_GTP_VER, 3'b000, 6, 0, 0, 0);
    issue_packet(PK_MSG_TYPE, 3'b000, 6, 0, 0, 0);
    issue_packet(PK_LENGTH, 3'b000, 10, 0, 1, 0);     // length one past the data
    issue_packet(PK_LENGTH, 3'b001, 10, 3, 4, 0);     // past the data with slack
    issue_packet(PK_LENGTH, 3'b010, 10, 0, -10, 0);   // optional part eats it all
    issue_packet(PK_NOISE, 3'b000, 0, 0, 0, 45);

    // random phases: port extremes, a random port, back to the default
    phase_port[0] = 16'd0;
    phase_port[1] = 16'hFFFF;
    phase_port[2] = 16'($urandom);
    phase_port[3] = gtpud_pkg::PORT_RESET;
    phase_rx[0]   = RX_ALWAYS;
    phase_rx[1]   = RX_PERIODIC;
    phase_rx[2]   = RX_SPARSE;
    phase_rx[3]   = RX_RANDOM;
    for (ph = 0; ph < 4; ph++) begin
      s_tvalid <= 1'b0;
      drain_verdicts();
      write_port(phase_port[ph]);
      rx_mode     = phase_rx[ph];
      stream_gaps = (ph != 0);   // first phase: back to back, no idling
      burst_left  = 0;
      if (ph == 1) hold_req = 1'b1;  // sender keeps going into the hold-off
      phase_bytes = 0;
      phase_pkts  = 0;
      while (phase_bytes < PHASE_BYTES || phase_pkts < PHASE_PKTS) random_packet();
    end

    s_tvalid <= 1'b0;
    drain_verdicts();

    $display("covered %0d packets in %0d bytes at five port settings, %0d verdicts checked",
             pkts_sent, bytes_sent, verdicts_checked);
    $display("status codes seen (8..0) %b, input back-pressured for %0d cycles",
             status_seen, in_stalls);
    if (fail_count == 0) begin
      $display("gtpu_uplink_deframer: match");
    end else begin
      $display("gtpu_uplink_deframer: mismatch");
    end
    $finish;
  end

endmodule
